>>> design/olve_pkg.sv
// Shared types and codes for the ordered value list engine.
`timescale 1ns / 1ps

package olve_pkg;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AFTER = 3'd2,
    OP_REMOVE    = 3'd3,
    OP_FIND      = 3'd4,
    OP_MODIFY    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] match_value;
    logic signed [31:0] new_value;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    logic       found;
    logic [4:0] count;
  } out_item_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        clr;
    logic        scan;
    logic        apply;
    op_t         op;
    logic [31:0] mv;
    logic [31:0] nv;
  } cell_ctl_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic        occ;
    logic        seen;
    logic        first;
    logic [31:0] val;
  } cell_link_t;

endpackage

>>> design/olve_cell.sv
// One list position: value, occupancy and the rippling match-seen flag.
`timescale 1ns / 1ps

module olve_cell import olve_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  logic [31:0] val_r, val_nxt;
  logic        occ_r, occ_nxt;
  logic        seen_r, seen_nxt;
  logic        first;
  logic        eq;

  assign first = seen_r & ~left.seen;
  assign eq    = occ_r && (val_r == ctl.mv);

  always_comb begin
    val_nxt  = val_r;
    occ_nxt  = occ_r;
    seen_nxt = seen_r;
    if (ctl.clr) begin
      seen_nxt = 1'b0;
    end else if (ctl.scan) begin
      seen_nxt = left.seen | eq;
    end
    if (ctl.apply) begin
      case (ctl.op) inside
        OP_INS_FRONT, OP_INS_AFTER: begin
          occ_nxt = occ_r | left.occ;
          if (ctl.op == OP_INS_FRONT || left.seen) begin
            val_nxt = left.first ? ctl.nv : left.val;
          end
        end
        OP_INS_BACK: begin
          occ_nxt = occ_r | left.occ;
          if (!occ_r && left.occ) begin
            val_nxt = ctl.nv;
          end
        end
        OP_REMOVE: begin
          if (seen_r) begin
            val_nxt = right.val;
            occ_nxt = right.occ;
          end
        end
        OP_MODIFY: begin
          if (first) begin
            val_nxt = ctl.nv;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r  <= 1'b0;
      seen_r <= 1'b0;
    end else begin
      occ_r  <= occ_nxt;
      seen_r <= seen_nxt;
    end
    val_r <= val_nxt;
  end

  assign link = '{occ: occ_r, seen: seen_r, first: first, val: val_r};

endmodule

>>> design/ordered_value_list_engine.sv
// out_valid is raised from the S_APPLY state, which is entered straight from accept for insert
// front/back, remove on an empty list and unused codes, and after the S_SCAN state for match
// operations, whose match flag ripples one cell per cycle down the cell chain.
// Only one transaction is in work at a time: in_stall holds until S_APPLY has registered the
// result, and S_APPLY waits while an earlier result still waits on out_stall.
// Reset (synchronous, rst_n low) empties the list and drops any pending result.
`timescale 1ns / 1ps

module ordered_value_list_engine import olve_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = $clog2(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_t;

  state_t          state_r;
  logic [SW-1:0]   scan_cnt_r;
  logic [CW-1:0]   count_r, count_nxt;
  op_t             op_r;
  logic [31:0]     mv_r;
  logic [31:0]     nv_r;
  logic            out_valid_r;
  out_item_t       out_data_r;

  cell_ctl_t       ctl;
  cell_link_t      lnk [CAPACITY];
  cell_link_t      head, tail;
  logic [CAPACITY-1:0] occ_vec;

  logic            in_accept;
  logic            out_free;
  logic            need_scan;
  logic            found;
  logic            full;
  logic            go;
  status_t         res_status;
  logic            res_found;
  logic [CW+4:0]   count_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign found     = lnk[CAPACITY-1].seen;
  assign full      = (count_r == CW'(CAPACITY));

  assign need_scan = (in_data.op == OP_INS_AFTER || in_data.op == OP_FIND ||
                      in_data.op == OP_MODIFY ||
                      (in_data.op == OP_REMOVE && count_r != '0));

  always_comb begin
    res_status = ST_OK;
    res_found  = 1'b0;
    go         = 1'b0;
    count_nxt  = count_r;
    unique case (op_r) inside
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          go        = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_INS_AFTER: begin
        res_found = found;
        if (!found) begin
          res_status = ST_NOT_FOUND;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          go        = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        res_found = found;
        if (count_r == '0) begin
          res_status = ST_EMPTY;
        end else if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          go        = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_FIND: begin
        res_found = found;
        if (!found) res_status = ST_NOT_FOUND;
      end
      OP_MODIFY: begin
        res_found = found;
        if (!found) begin
          res_status = ST_NOT_FOUND;
        end else begin
          go = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign count_ext = {5'd0, count_nxt};

  assign ctl = '{clr:   in_accept,
                 scan:  (state_r == S_SCAN),
                 apply: (state_r == S_APPLY) && out_free && go,
                 op:    op_r,
                 mv:    mv_r,
                 nv:    nv_r};

  assign head = '{occ: 1'b1, seen: 1'b0, first: (op_r == OP_INS_FRONT), val: '0};
  assign tail = '{occ: 1'b0, seen: 1'b0, first: 1'b0, val: '0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t l_in, r_in;
    if (i == 0) begin : g_head
      assign l_in = head;
    end else begin : g_left
      assign l_in = lnk[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_in = tail;
    end else begin : g_right
      assign r_in = lnk[i+1];
    end
    olve_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .left  (l_in),
      .right (r_in),
      .link  (lnk[i])
    );
    assign occ_vec[i] = lnk[i].occ;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_cnt_r  <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            scan_cnt_r <= '0;
            state_r    <= need_scan ? S_SCAN : S_APPLY;
          end
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + SW'(1);
          if (scan_cnt_r == SW'(CAPACITY - 1)) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (out_free) begin
            count_r     <= count_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (in_accept) begin
      op_r <= in_data.op;
      mv_r <= in_data.match_value;
      nv_r <= in_data.new_value;
    end
    if (state_r == S_APPLY && out_free) begin
      out_data_r <= '{status: res_status, found: res_found, count: count_ext[4:0]};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(occ_vec) == int'(count_r))
    else $error("cell occupancy disagrees with element count");

  a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_APPLY))
    else $error("result raised outside apply");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r != S_IDLE)
    else $error("accepted transaction not taken into work");

endmodule
